/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ERFF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ERFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/erff_pkg.sv */
// ----------------------------------------------------------------------------
// erff_pkg
// Types, stage offsets and Q24.24 arithmetic steps shared by the Rusanov
// flux fluctuation pipeline.
// ----------------------------------------------------------------------------
package erff_pkg;

    localparam int MUL_LAT   = 4;
    localparam int DIV_STEPS = 48;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int SQ_STEPS  = 36;

    // Stage numbers counted from the input register (stage 0).
    localparam int T_SUMSQ = MUL_LAT + 1;
    localparam int T_DIV1  = T_SUMSQ + DIV_LAT;
    localparam int T_D     = T_DIV1 + 1;
    localparam int T_P     = T_D + MUL_LAT;
    localparam int T_GP    = T_P + MUL_LAT;
    localparam int T_C2    = T_GP + DIV_LAT;
    localparam int T_ROOT  = T_C2 + SQ_STEPS;
    localparam int T_SPEED = T_ROOT + 1;
    localparam int T_FIN   = T_SPEED - MUL_LAT;
    localparam int T_OUT   = T_SPEED + 1;
    localparam int T_S     = T_OUT + 1;
    localparam int T_T     = T_S + MUL_LAT;
    localparam int T_LAST  = T_T + 1;

    localparam logic [1:0] DIR_X = 2'd0;
    localparam logic [1:0] DIR_Y = 2'd1;
    localparam logic [1:0] DIR_Z = 2'd2;

    localparam logic [25:0] GAMMA_RESET = 26'd23488102;
    localparam logic signed [26:0] Q_ONE = 27'sh100_0000;

    typedef logic signed [47:0] t_q;
    typedef logic [4:0][47:0] t_qv;
    typedef logic [2:0][2:0] t_axes;

    localparam t_q Q_MAX = {1'b0, {47{1'b1}}};
    localparam t_q Q_MIN = {1'b1, 47'b0};

    typedef struct packed {
        logic [47:0] ma;
        logic [47:0] mb;
        logic        neg;
    } t_mul_a;

    typedef struct packed {
        logic [47:0] ll;
        logic [47:0] lh;
        logic [47:0] hl;
        logic [47:0] hh;
        logic        neg;
    } t_mul_b;

    typedef struct packed {
        logic [95:0] p;
        logic        neg;
    } t_mul_c;

    typedef struct packed {
        logic [47:0] rem;
        logic [47:0] q;
        logic [47:0] den;
        logic [23:0] low;
        logic        neg;
        logic        over;
    } t_div;

    typedef struct packed {
        logic [39:0] rem;
        logic [35:0] root;
        logic [47:0] bits;
    } t_sqrt;

    typedef struct packed {
        t_qv         q;
        logic [1:0]  dir;
        logic        ok;
        logic [47:0] u;
        logic [47:0] au;
        logic [47:0] p;
        logic [47:0] ep;
        logic [47:0] speed;
    } t_carry;

    typedef struct packed {
        t_qv         flux;
        t_qv         q;
        logic [47:0] speed;
        logic        ok;
    } t_side_out;

    typedef struct packed {
        t_qv  df;
        logic ok;
    } t_tcarry;

    function automatic t_axes axes(input logic [1:0] dir);
        t_axes a;
        unique case (dir)
            DIR_Y: a = {3'd1, 3'd3, 3'd2};
            DIR_Z: a = {3'd2, 3'd1, 3'd3};
            default: a = {3'd3, 3'd2, 3'd1};
        endcase
        return a;
    endfunction

    function automatic t_q sat49(input logic [48:0] v);
        if (v[48] != v[47]) begin
            return v[48] ? Q_MIN : Q_MAX;
        end
        return v[47:0];
    endfunction

    function automatic t_q add_sat(input t_q a, input t_q b);
        return sat49({a[47], a} + {b[47], b});
    endfunction

    function automatic t_q sub_sat(input t_q a, input t_q b);
        return sat49({a[47], a} - {b[47], b});
    endfunction

    // Halving that truncates toward zero, on a sum that grew one bit.
    function automatic t_q half_sat(input logic [48:0] x);
        logic [48:0] y;
        y = x + {48'b0, x[48]};
        return sat49({y[48], y[48:1]});
    endfunction

    function automatic logic [47:0] mag(input t_q v);
        return v[47] ? 48'(~v + 48'd1) : v;
    endfunction

    function automatic t_q abs_sat(input t_q v);
        if (v == Q_MIN) begin
            return Q_MAX;
        end
        return t_q'(mag(v));
    endfunction

    function automatic t_q clamp_mag(input logic [71:0] m, input logic neg);
        if (neg) begin
            if (m >= 72'h8000_0000_0000) begin
                return Q_MIN;
            end
            return t_q'(48'd0 - m[47:0]);
        end
        if (m > 72'h7FFF_FFFF_FFFF) begin
            return Q_MAX;
        end
        return m[47:0];
    endfunction

    function automatic t_mul_a mul_a(input t_q a, input t_q b);
        t_mul_a r;
        r.ma  = mag(a);
        r.mb  = mag(b);
        r.neg = a[47] ^ b[47];
        return r;
    endfunction

    function automatic t_mul_b mul_b(input t_mul_a a);
        t_mul_b r;
        r.ll  = 48'(a.ma[23:0]) * 48'(a.mb[23:0]);
        r.lh  = 48'(a.ma[23:0]) * 48'(a.mb[47:24]);
        r.hl  = 48'(a.ma[47:24]) * 48'(a.mb[23:0]);
        r.hh  = 48'(a.ma[47:24]) * 48'(a.mb[47:24]);
        r.neg = a.neg;
        return r;
    endfunction

    function automatic t_mul_c mul_c(input t_mul_b b);
        t_mul_c r;
        r.p   = {b.hh, b.ll} + ({48'b0, b.lh} << 24) + ({48'b0, b.hl} << 24);
        r.neg = b.neg;
        return r;
    endfunction

    // Rounds half a unit up on the magnitude, then drops the fraction.
    function automatic t_q mul_d(input t_mul_c c);
        logic [95:0] t;
        t = c.p + 96'h80_0000;
        return clamp_mag(t[95:24], c.neg);
    endfunction

    // The quotient overflows 48 bits exactly when the integer part of the
    // magnitude reaches the divisor, so only 48 quotient bits are developed.
    function automatic t_div div_pre(input t_q num, input logic [47:0] den);
        t_div        r;
        logic [47:0] m;
        m      = mag(num);
        r.rem  = {24'b0, m[47:24]};
        r.low  = m[23:0];
        r.q    = '0;
        r.den  = den;
        r.neg  = num[47];
        r.over = ({24'b0, m[47:24]} >= den);
        return r;
    endfunction

    function automatic t_div div_step(input t_div d);
        t_div        r;
        logic [48:0] t;
        r = d;
        t = {d.rem, d.low[23]};
        if (t >= {1'b0, d.den}) begin
            r.rem = 48'(t - {1'b0, d.den});
            r.q   = {d.q[46:0], 1'b1};
        end else begin
            r.rem = t[47:0];
            r.q   = {d.q[46:0], 1'b0};
        end
        r.low = {d.low[22:0], 1'b0};
        return r;
    endfunction

    function automatic t_q div_fin(input t_div d);
        logic [48:0] q1;
        q1 = {1'b0, d.q} + {48'b0, ({d.rem, 1'b0} >= {1'b0, d.den})};
        if (d.over) begin
            return d.neg ? Q_MIN : Q_MAX;
        end
        return clamp_mag({23'b0, q1}, d.neg);
    endfunction

    function automatic t_sqrt sqrt_init(input t_q x);
        t_sqrt r;
        r.rem  = '0;
        r.root = '0;
        r.bits = x;
        return r;
    endfunction

    // One result bit per step; the low twelve pairs are zero fraction.
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       r;
        logic [39:0] r4;
        logic [37:0] trial;
        r4    = {s.rem[37:0], s.bits[47:46]};
        trial = {s.root, 2'b01};
        if (r4 >= {2'b0, trial}) begin
            r.rem  = r4 - {2'b0, trial};
            r.root = {s.root[34:0], 1'b1};
        end else begin
            r.rem  = r4;
            r.root = {s.root[34:0], 1'b0};
        end
        r.bits = {s.bits[45:0], 2'b00};
        return r;
    endfunction

endpackage

/* design/erff_side.sv */
// ----------------------------------------------------------------------------
// erff_side
// Pipelined pressure, normal velocity, wave speed and normal flux of one
// conserved state. Each divider and the square root develop one bit per stage.
// ----------------------------------------------------------------------------
module erff_side (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [25:0]            i_gamma,
    input  logic [1:0]             i_dir,
    input  erff_pkg::t_qv          i_q,
    output erff_pkg::t_side_out    o_side
);

    localparam int NLANE = 9;
    localparam int L_SQ  = 0;
    localparam int L_P   = 3;
    localparam int L_GP  = 4;
    localparam int L_F   = 5;
    localparam int NDIV  = 3;
    localparam int D_KE  = 0;
    localparam int D_U   = 1;
    localparam int D_C2  = 2;

    erff_pkg::t_carry    r_c   [1:erff_pkg::T_SPEED];
    erff_pkg::t_carry    n_c   [1:erff_pkg::T_SPEED];
    erff_pkg::t_mul_a    r_ma  [NLANE];
    erff_pkg::t_mul_b    r_mb  [NLANE];
    erff_pkg::t_mul_c    r_mc  [NLANE];
    erff_pkg::t_q        r_md  [NLANE];
    logic [47:0]         w_la  [NLANE];
    logic [47:0]         w_lb  [NLANE];
    erff_pkg::t_div      r_dv  [NDIV][0:erff_pkg::DIV_STEPS];
    erff_pkg::t_q        r_dq  [NDIV];
    logic [47:0]         w_num [NDIV];
    logic [47:0]         w_den [NDIV];
    erff_pkg::t_sqrt     r_sq  [erff_pkg::SQ_STEPS];
    erff_pkg::t_q        r_ss;
    erff_pkg::t_q        r_d;
    erff_pkg::t_side_out r_o;
    erff_pkg::t_side_out n_o;
    logic signed [26:0]  w_gm1;
    erff_pkg::t_axes     w_ax_div;
    erff_pkg::t_axes     w_ax_fin;
    erff_pkg::t_axes     w_ax_out;

    assign w_gm1    = $signed({1'b0, i_gamma}) - erff_pkg::Q_ONE;
    assign w_ax_div = erff_pkg::axes(r_c[erff_pkg::T_SUMSQ].dir);
    assign w_ax_fin = erff_pkg::axes(r_c[erff_pkg::T_FIN].dir);
    assign w_ax_out = erff_pkg::axes(r_c[erff_pkg::T_SPEED].dir);

    always_comb begin
        n_c[1]       = '0;
        n_c[1].q     = i_q;
        n_c[1].dir   = i_dir;
        n_c[1].ok    = ($signed(i_q[0]) > 48'sd0);
        for (int k = 2; k <= erff_pkg::T_SPEED; k++) begin
            n_c[k] = r_c[k-1];
            if (k == erff_pkg::T_D) begin
                n_c[k].u  = r_dq[D_U];
                n_c[k].au = erff_pkg::abs_sat(r_dq[D_U]);
            end
            if (k == erff_pkg::T_P + 1) begin
                n_c[k].p = r_md[L_P];
            end
            if (k == erff_pkg::T_C2 + 1) begin
                // A negative squared sound speed marks the state as unphysical.
                n_c[k].ok = r_c[k-1].ok & ~r_dq[D_C2][47];
            end
            if (k == erff_pkg::T_FIN) begin
                n_c[k].ep = erff_pkg::add_sat(r_c[k-1].q[4], r_c[k-1].p);
            end
            if (k == erff_pkg::T_SPEED) begin
                n_c[k].speed = erff_pkg::add_sat(r_c[k-1].au,
                    {12'b0, r_sq[erff_pkg::SQ_STEPS-1].root});
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_la[L_SQ+j] = i_q[j+1];
            w_lb[L_SQ+j] = i_q[j+1];
            w_la[L_F+j]  = r_c[erff_pkg::T_FIN].q[w_ax_fin[j]];
            w_lb[L_F+j]  = r_c[erff_pkg::T_FIN].u;
        end
        w_la[L_P]   = {{21{w_gm1[26]}}, w_gm1};
        w_lb[L_P]   = r_d;
        w_la[L_GP]  = {22'b0, i_gamma};
        w_lb[L_GP]  = r_md[L_P];
        w_la[L_F+3] = r_c[erff_pkg::T_FIN].ep;
        w_lb[L_F+3] = r_c[erff_pkg::T_FIN].u;
    end

    always_comb begin
        w_num[D_KE] = r_ss;
        w_den[D_KE] = {r_c[erff_pkg::T_SUMSQ].q[0][46:0], 1'b0};
        w_num[D_U]  = r_c[erff_pkg::T_SUMSQ].q[w_ax_div[0]];
        w_den[D_U]  = r_c[erff_pkg::T_SUMSQ].q[0];
        w_num[D_C2] = r_md[L_GP];
        w_den[D_C2] = r_c[erff_pkg::T_GP].q[0];
    end

    always_comb begin
        n_o                  = '0;
        n_o.q                = r_c[erff_pkg::T_SPEED].q;
        n_o.speed            = r_c[erff_pkg::T_SPEED].speed;
        n_o.ok               = r_c[erff_pkg::T_SPEED].ok;
        n_o.flux[0]          = r_c[erff_pkg::T_SPEED].q[w_ax_out[0]];
        n_o.flux[4]          = r_md[L_F+3];
        n_o.flux[w_ax_out[0]] = erff_pkg::add_sat(r_md[L_F], r_c[erff_pkg::T_SPEED].p);
        n_o.flux[w_ax_out[1]] = r_md[L_F+1];
        n_o.flux[w_ax_out[2]] = r_md[L_F+2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 1; k <= erff_pkg::T_SPEED; k++) begin
                r_c[k] <= n_c[k];
            end
            for (int l = 0; l < NLANE; l++) begin
                r_ma[l] <= erff_pkg::mul_a(w_la[l], w_lb[l]);
                r_mb[l] <= erff_pkg::mul_b(r_ma[l]);
                r_mc[l] <= erff_pkg::mul_c(r_mb[l]);
                r_md[l] <= erff_pkg::mul_d(r_mc[l]);
            end
            for (int d = 0; d < NDIV; d++) begin
                r_dv[d][0] <= erff_pkg::div_pre(w_num[d], w_den[d]);
                for (int j = 1; j <= erff_pkg::DIV_STEPS; j++) begin
                    r_dv[d][j] <= erff_pkg::div_step(r_dv[d][j-1]);
                end
                r_dq[d] <= erff_pkg::div_fin(r_dv[d][erff_pkg::DIV_STEPS]);
            end
            r_sq[0] <= erff_pkg::sqrt_step(erff_pkg::sqrt_init(r_dq[D_C2]));
            for (int j = 1; j < erff_pkg::SQ_STEPS; j++) begin
                r_sq[j] <= erff_pkg::sqrt_step(r_sq[j-1]);
            end
            r_ss <= erff_pkg::add_sat(erff_pkg::add_sat(r_md[L_SQ], r_md[L_SQ+1]),
                                      r_md[L_SQ+2]);
            r_d  <= erff_pkg::sub_sat(r_c[erff_pkg::T_DIV1].q[4], r_dq[D_KE]);
            r_o  <= n_o;
        end
    end

    assign o_side = r_o;

endmodule

/* design/euler_rusanov_flux_fluctuation.sv */
// ----------------------------------------------------------------------------
// euler_rusanov_flux_fluctuation
// Rusanov (local Lax-Friedrichs) flux fluctuations of the 3-D Euler equations
// for an ideal gas, signed Q24.24, one interface per request.
//
//   channel   direction  payload
//   s_axis    in         tdata: left rho, mx, my, mz, E, right rho..E; tuser: dir
//   m_axis    out        tdata: minus rho..E, plus rho..E; tuser: invalid_state
//   cfg       in         gas_gamma, written with i_cfg_wr_en
//
// One request enters per cycle while the output register is empty or read; each
// result passes through the two chained 48-step dividers, the 36-step square
// root and the four-stage multipliers.
// Reset clears the valid bits and loads gas_gamma with 1.4.
// The whole pipeline advances whenever the output register is empty or read,
// so a stall holds every stage in place.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_rusanov_flux_fluctuation (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [25:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_density, left_momentum_x/y/z, left_energy, right_density,
    // right_momentum_x/y/z, right_energy (48 bits each, lowest first)
    input  logic [479:0] s_axis_tdata,
    // direction
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // minus_density, minus_momentum_x/y/z, minus_energy, plus_density,
    // plus_momentum_x/y/z, plus_energy (48 bits each, lowest first)
    output logic [479:0] m_axis_tdata,
    // invalid_state
    output logic [0:0]   m_axis_tuser
);

    localparam int T_S    = erff_pkg::T_S;
    localparam int T_T    = erff_pkg::T_T;
    localparam int T_LAST = erff_pkg::T_LAST;

    logic [25:0]         r_gamma;
    logic [T_LAST:0]     r_v;
    logic                w_en;
    logic [1:0]          r_dir;
    erff_pkg::t_qv       r_left;
    erff_pkg::t_qv       r_right;
    erff_pkg::t_side_out w_sl;
    erff_pkg::t_side_out w_sr;
    erff_pkg::t_q        r_s;
    erff_pkg::t_qv       r_dq;
    erff_pkg::t_tcarry   r_tc   [T_S:T_T];
    erff_pkg::t_tcarry   n_tc;
    erff_pkg::t_mul_a    r_tma  [5];
    erff_pkg::t_mul_b    r_tmb  [5];
    erff_pkg::t_mul_c    r_tmc  [5];
    erff_pkg::t_q        r_tmd  [5];
    erff_pkg::t_qv       r_minus;
    erff_pkg::t_qv       r_plus;
    erff_pkg::t_qv       n_minus;
    erff_pkg::t_qv       n_plus;
    logic                r_inv;

    assign w_en          = ~r_v[T_LAST] | m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_v[T_LAST];
    assign m_axis_tdata  = {r_plus, r_minus};
    assign m_axis_tuser  = r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= erff_pkg::GAMMA_RESET;
        end else if (i_cfg_wr_en) begin
            r_gamma <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[T_LAST-1:0], s_axis_tvalid};
        end
    end

    erff_side u_left (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_gamma (r_gamma),
        .i_dir   (r_dir),
        .i_q     (r_left),
        .o_side  (w_sl)
    );

    erff_side u_right (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_gamma (r_gamma),
        .i_dir   (r_dir),
        .i_q     (r_right),
        .o_side  (w_sr)
    );

    always_comb begin
        n_tc.ok = w_sl.ok & w_sr.ok;
        for (int k = 0; k < 5; k++) begin
            n_tc.df[k] = erff_pkg::sub_sat(w_sr.flux[k], w_sl.flux[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n_minus[k] = erff_pkg::half_sat({r_tc[T_T].df[k][47], r_tc[T_T].df[k]}
                                            - {r_tmd[k][47], r_tmd[k]});
            n_plus[k]  = erff_pkg::half_sat({r_tc[T_T].df[k][47], r_tc[T_T].df[k]}
                                            + {r_tmd[k][47], r_tmd[k]});
        end
        // An unphysical state on either side forces all fluctuations to zero.
        if (!r_tc[T_T].ok) begin
            n_minus = '0;
            n_plus  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dir   <= s_axis_tuser;
            r_left  <= s_axis_tdata[239:0];
            r_right <= s_axis_tdata[479:240];
            r_s     <= ($signed(w_sl.speed) > $signed(w_sr.speed)) ? w_sl.speed
                                                                   : w_sr.speed;
            for (int k = 0; k < 5; k++) begin
                r_dq[k] <= erff_pkg::sub_sat(w_sr.q[k], w_sl.q[k]);
            end
            r_tc[T_S] <= n_tc;
            for (int k = T_S + 1; k <= T_T; k++) begin
                r_tc[k] <= r_tc[k-1];
            end
            for (int k = 0; k < 5; k++) begin
                r_tma[k] <= erff_pkg::mul_a(r_s, r_dq[k]);
                r_tmb[k] <= erff_pkg::mul_b(r_tma[k]);
                r_tmc[k] <= erff_pkg::mul_c(r_tmb[k]);
                r_tmd[k] <= erff_pkg::mul_d(r_tmc[k]);
            end
            r_minus <= n_minus;
            r_plus  <= n_plus;
            r_inv   <= ~r_tc[T_T].ok;
        end
    end

    `ERFF_ASSERT_IMPL(a_inv_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "invalid result carries nonzero data")
    `ERFF_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !w_en, r_v[T_LAST], "pipeline stalled with empty output register")
    `ERFF_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_v), "valid bits moved during a stall")
    `ERFF_ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n, i_cfg_wr_en, r_gamma == $past(i_cfg_wr_data), "gas_gamma write lost")

endmodule
